/* sv/pump_link_frame_checker_core_macros.svh */
// Assertion macros for the pump link frame checker.
// Every macro expects signals named clk and rst_n in the scope that uses it.
`ifndef PUMP_LINK_FRAME_CHECKER_CORE_MACROS_SVH
`define PUMP_LINK_FRAME_CHECKER_CORE_MACROS_SVH

// Hold a property on every edge outside reset.
`define PLK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Hold an implication from one edge to the next, outside reset.
`define PLK_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/plk_pkg.sv */
// Shared types, character codes and defaults for the pump link frame checker.
// No dependencies; every other source file but the macro header imports it.
package plk_pkg;

  localparam int unsigned MAX_FRAME_DEF = 256;
  localparam logic [19:0] GAP_LIMIT_RST = 20'(1193 * 25);

  localparam int unsigned IN_W  = 48;
  localparam int unsigned OUT_W = 48;

  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_T       = 8'h54;
  localparam logic [7:0] CH_F       = 8'h46;
  localparam logic [7:0] CH_BANG    = 8'h21;
  localparam logic [7:0] CH_ONE     = 8'h31;
  localparam logic [7:0] CH_AT      = 8'h40;
  localparam logic [7:0] CH_A       = 8'h41;
  localparam logic [7:0] CH_H       = 8'h48;
  localparam logic [7:0] DIGIT_BASE = 8'h30;
  localparam logic [7:0] LRC_MASK   = 8'h3F;
  localparam logic [7:0] LRC_BASE   = 8'h30;
  localparam logic [7:0] NOZ_BASE   = 8'h3B;
  localparam logic [7:0] NOZ_END    = 8'h80;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_SHORT      = 3'd1,
    ST_LRC_BAD    = 3'd2,
    ST_BAD_DIR    = 3'd3,
    ST_BAD_PUMP   = 3'd4,
    ST_BAD_PREPAY = 3'd5,
    ST_TOO_LONG   = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    END_CR   = 2'd0,
    END_GAP  = 2'd1,
    END_CHAN = 2'd2
  } cause_t;

  // Frame state handed from the tracker to the decoder when a frame ends
  typedef struct packed {
    logic            fire;
    cause_t          cause;
    logic            overflowed;
    logic [7:0]      lrc_sum;
    logic [7:0]      prev_byte;
    logic [4:0][7:0] hdr;
  } snap_t;

  typedef struct packed {
    logic [8:0] payload_length;
    logic [1:0] hose_number;
    logic [3:0] nozzle_flags;
    logic       nozzle_valid;
    logic [7:0] command_code;
    logic [7:0] lockout_code;
    logic       prepay;
    logic [4:0] pump_number;
    logic       is_master;
    cause_t     end_cause;
    status_t    frame_status;
  } result_t;

endpackage

/* sv/pump_link_frame_checker_core.sv */
// An item taken into the input register that ends a frame loads the result register behind out_*.
// Throughput: one item per cycle; a stall on the result side holds only items
// that end a frame, set by the single result register.
// Reset (rst_n low, synchronous): both stages empty, hunting for a start mark,
// gap limit back to 29825 ticks. Header bytes need no reset.
// Depends on plk_pkg, plk_tracker and plk_decode.
module pump_link_frame_checker_core #(
  parameter int unsigned MAX_FRAME = plk_pkg::MAX_FRAME_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // [7:0] data_byte, [15:8] channel, [47:16] time_ticks
  input  logic [plk_pkg::IN_W-1:0]  in_tdata,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // [2:0] frame_status, [4:3] end_cause, [5] is_master, [10:6] pump_number,
  // [11] prepay, [19:12] lockout_code, [27:20] command_code, [28] nozzle_valid,
  // [32:29] nozzle_flags, [34:33] hose_number, [43:35] payload_length, [47:44] 0
  output logic [plk_pkg::OUT_W-1:0] out_tdata,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [19:0]               cfg_data
);
  import plk_pkg::*;

  localparam int unsigned FLW = $clog2(MAX_FRAME + 1);

  logic              in_vld_r;
  logic [IN_W-1:0]   in_data_r;
  logic              out_vld_r;
  logic [OUT_W-1:0]  out_data_r;
  logic [19:0]       gap_limit_r;

  snap_t             snap;
  logic [FLW-1:0]    frame_len;
  result_t           res;
  logic              out_free, advance;

  assign cfg_ready  = 1'b1;
  assign out_free   = !out_vld_r || out_tready;
  assign advance    = in_vld_r && (!snap.fire || out_free);
  assign in_tready  = !in_vld_r || advance;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  plk_tracker #(.MAX_FRAME(MAX_FRAME)) u_tracker (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (advance),
    .data_byte  (in_data_r[7:0]),
    .channel    (in_data_r[15:8]),
    .time_ticks (in_data_r[47:16]),
    .gap_limit  (gap_limit_r),
    .snap       (snap),
    .frame_len  (frame_len)
  );

  plk_decode #(.MAX_FRAME(MAX_FRAME)) u_decode (
    .snap      (snap),
    .frame_len (frame_len),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_limit_r <= GAP_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      gap_limit_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_data_r <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance && snap.fire) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && snap.fire) begin
      out_data_r <= {4'd0, res.payload_length, res.hose_number, res.nozzle_flags,
                     res.nozzle_valid, res.command_code, res.lockout_code,
                     res.prepay, res.pump_number, res.is_master, res.end_cause,
                     res.frame_status};
    end
  end

endmodule

/* sv/plk_tracker.sv */
// Frame tracker: hunt for the start mark, detect frame breaks, gather the
// header and running LRC sum. Depends on plk_pkg.
module plk_tracker #(
  parameter int unsigned MAX_FRAME = plk_pkg::MAX_FRAME_DEF,
  localparam int unsigned FLW = $clog2(MAX_FRAME + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [7:0]          data_byte,
  input  logic [7:0]          channel,
  input  logic [31:0]         time_ticks,
  input  logic [19:0]         gap_limit,
  output plk_pkg::snap_t      snap,
  output logic [FLW-1:0]      frame_len
);
  import plk_pkg::*;

  logic            in_frame_r, in_frame_nxt;
  logic [7:0]      cur_channel_r, cur_channel_nxt;
  logic [31:0]     last_stamp_r, last_stamp_nxt;
  logic [FLW-1:0]  frame_len_r, frame_len_nxt;
  logic [7:0]      lrc_sum_r, lrc_sum_nxt;
  logic [7:0]      prev_byte_r, prev_byte_nxt;
  logic            overflowed_r, overflowed_nxt;
  logic [4:0][7:0] hdr_r;

  logic [31:0] gap;
  logic        brk_chan, brk_gap, is_cr, do_hunt, do_app, full, hdr_we;
  logic [2:0]  hdr_idx;

  always_comb begin
    gap      = time_ticks - last_stamp_r;
    brk_chan = in_frame_r && (channel != cur_channel_r);
    brk_gap  = in_frame_r && !brk_chan && (gap > {12'd0, gap_limit});
    is_cr    = in_frame_r && !brk_chan && !brk_gap && (data_byte == CH_CR);
    do_hunt  = !in_frame_r || brk_chan || brk_gap;
    do_app   = in_frame_r && !brk_chan && !brk_gap && !is_cr;
    full     = frame_len_r >= FLW'(MAX_FRAME);
    hdr_idx  = 3'(frame_len_r - FLW'(1));
    hdr_we   = do_app && !full && (frame_len_r >= FLW'(1)) && (frame_len_r <= FLW'(5));

    in_frame_nxt    = in_frame_r;
    cur_channel_nxt = cur_channel_r;
    last_stamp_nxt  = last_stamp_r;
    frame_len_nxt   = frame_len_r;
    lrc_sum_nxt     = lrc_sum_r;
    prev_byte_nxt   = prev_byte_r;
    overflowed_nxt  = overflowed_r;

    if (do_hunt) begin
      // restart the hunt at this byte
      cur_channel_nxt = channel;
      last_stamp_nxt  = time_ticks;
      in_frame_nxt    = (data_byte == CH_STAR);
      if (data_byte == CH_STAR) begin
        frame_len_nxt  = FLW'(1);
        lrc_sum_nxt    = '0;
        overflowed_nxt = 1'b0;
        prev_byte_nxt  = data_byte;
      end
    end else if (is_cr) begin
      last_stamp_nxt = time_ticks;
      in_frame_nxt   = 1'b0;
    end else begin
      last_stamp_nxt = time_ticks;
      if (full) begin
        // drop the byte, mark the frame too long
        overflowed_nxt = 1'b1;
      end else begin
        if (frame_len_r >= FLW'(2)) begin
          lrc_sum_nxt = lrc_sum_r + data_byte;
        end
        prev_byte_nxt = data_byte;
        frame_len_nxt = frame_len_r + FLW'(1);
      end
    end

    snap.fire       = brk_chan || brk_gap || is_cr;
    snap.cause      = brk_chan ? END_CHAN : (brk_gap ? END_GAP : END_CR);
    snap.overflowed = overflowed_r;
    snap.lrc_sum    = lrc_sum_r;
    snap.prev_byte  = prev_byte_r;
    snap.hdr        = hdr_r;
    frame_len       = frame_len_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r    <= 1'b0;
      cur_channel_r <= '0;
      last_stamp_r  <= '0;
      frame_len_r   <= '0;
      lrc_sum_r     <= '0;
      prev_byte_r   <= '0;
      overflowed_r  <= 1'b0;
    end else if (step) begin
      in_frame_r    <= in_frame_nxt;
      cur_channel_r <= cur_channel_nxt;
      last_stamp_r  <= last_stamp_nxt;
      frame_len_r   <= frame_len_nxt;
      lrc_sum_r     <= lrc_sum_nxt;
      prev_byte_r   <= prev_byte_nxt;
      overflowed_r  <= overflowed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step && hdr_we) begin
      hdr_r[hdr_idx] <= data_byte;
    end
  end

endmodule

/* sv/plk_decode.sv */
// Frame decoder: LRC check and header field decoding of a finished frame.
// Depends on plk_pkg.
module plk_decode #(
  parameter int unsigned MAX_FRAME = plk_pkg::MAX_FRAME_DEF,
  localparam int unsigned FLW = $clog2(MAX_FRAME + 1)
) (
  input  plk_pkg::snap_t   snap,
  input  logic [FLW-1:0]   frame_len,
  output plk_pkg::result_t res
);
  import plk_pkg::*;

  logic [7:0] sum, lrc, pp_byte, nz, v;
  logic       dir_t, dir_f, pump_ok, pp_ok;
  logic [4:0] pump;
  logic [8:0] pay_master, pay_reply;

  always_comb begin
    sum     = snap.lrc_sum - snap.prev_byte;
    lrc     = (~sum & LRC_MASK) + LRC_BASE;
    dir_t   = snap.hdr[0] == CH_T;
    dir_f   = snap.hdr[0] == CH_F;
    pump_ok = (snap.hdr[1] == CH_BANG) ||
              ((snap.hdr[1] >= CH_ONE) && (snap.hdr[1] <= CH_AT));
    pump    = (snap.hdr[1] == CH_BANG) ? 5'd0 : 5'(snap.hdr[1] - DIGIT_BASE);
    pp_byte = dir_t ? snap.hdr[2] : snap.hdr[4];
    pp_ok   = (pp_byte == CH_A) || (pp_byte == CH_H);
    nz      = snap.hdr[2];
    v       = nz - NOZ_BASE;
    pay_master = 9'(frame_len - FLW'(7));
    pay_reply  = (frame_len >= FLW'(8)) ? 9'(frame_len - FLW'(8)) : 9'd0;

    res           = '0;
    res.end_cause = snap.cause;

    priority if (snap.overflowed) begin
      res.frame_status = ST_TOO_LONG;
    end else if (frame_len < FLW'(7)) begin
      res.frame_status = ST_SHORT;
    end else if (lrc != snap.prev_byte) begin
      res.frame_status = ST_LRC_BAD;
    end else if (!dir_t && !dir_f) begin
      res.frame_status = ST_BAD_DIR;
    end else if (!pump_ok) begin
      res.frame_status = ST_BAD_PUMP;
      res.is_master    = dir_t;
    end else if (!pp_ok) begin
      res.frame_status = ST_BAD_PREPAY;
      res.is_master    = dir_t;
      res.pump_number  = pump;
    end else begin
      res.frame_status = ST_OK;
      res.is_master    = dir_t;
      res.pump_number  = pump;
      res.prepay       = pp_byte == CH_H;
      if (dir_t) begin
        res.lockout_code   = snap.hdr[3];
        res.command_code   = snap.hdr[4];
        res.payload_length = pay_master;
      end else begin
        res.lockout_code   = snap.hdr[4];
        res.command_code   = snap.hdr[3];
        res.payload_length = pay_reply;
        if ((nz >= NOZ_BASE) && (nz < NOZ_END)) begin
          res.nozzle_valid = 1'b1;
          res.nozzle_flags = {v[5], v[2:0]};
          res.hose_number  = ~v[4:3];
        end
      end
    end
  end

endmodule

/* sv/plk_checker.sv */
// Port-level checks on the result channel of the frame checker, bound to the
// top level. Depends on plk_pkg and the assertion macro header.
`include "pump_link_frame_checker_core_macros.svh"

module plk_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      out_tvalid,
  input logic                      out_tready,
  input logic [plk_pkg::OUT_W-1:0] out_tdata
);
  import plk_pkg::*;

  `PLK_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result changed while stalled")
  `PLK_ASSERT(a_cause_code, !out_tvalid || (out_tdata[4:3] != 2'd3), "unknown end cause")
  `PLK_ASSERT(a_fail_zeroed, !out_tvalid || (out_tdata[2:0] == ST_OK) || (out_tdata[43:11] == '0), "fields set on a failed frame")
  `PLK_ASSERT(a_master_nozzle, !out_tvalid || (out_tdata[2:0] != ST_OK) || !out_tdata[5] || (out_tdata[34:28] == '0), "nozzle fields on a master frame")

endmodule

bind pump_link_frame_checker_core plk_checker u_plk_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

/* test/tb_pump_link_frame_checker_core.sv */
// Self-checking testbench for pump_link_frame_checker_core: directed table, then random frames.
// Accepted bytes step a local frame tracker; out_tdata must match its verdicts or typed rows.
// Depends on plk_pkg and the core RTL only.
module tb_pump_link_frame_checker_core;
  timeunit 1ns;
  timeprecision 1ps;

  import plk_pkg::*;

  localparam int unsigned WATCH_LIMIT = 3000;

  typedef enum logic [1:0] {
    TAIL_CR,
    TAIL_GAP,
    TAIL_CHAN
  } tail_t;

  typedef struct packed {
    logic [7:0]  b;
    logic [7:0]  ch;
    logic [31:0] t;
    logic        typed_exp;
    status_t     st;
    cause_t      cs;
  } step_row_t;

  // Directed bytes; typed rows carry an expected status and end cause, all else zero
  localparam step_row_t DIRECTED_STEPS [0:26] = '{
    '{8'h00,      8'h00, 32'd0,          1'b0, ST_OK,       END_CR},
    '{CH_STAR,    8'h00, 32'd10,         1'b0, ST_OK,       END_CR},
    '{CH_T,       8'h00, 32'd20,         1'b0, ST_OK,       END_CR},
    '{CH_ONE,     8'h00, 32'd30,         1'b0, ST_OK,       END_CR},
    '{CH_A,       8'h00, 32'd40,         1'b0, ST_OK,       END_CR},
    '{8'h30,      8'h00, 32'd50,         1'b0, ST_OK,       END_CR},
    '{8'h50,      8'h00, 32'd60,         1'b0, ST_OK,       END_CR},
    '{8'h3D,      8'h00, 32'd70,         1'b0, ST_OK,       END_CR},
    '{CH_CR,      8'h00, 32'd80,         1'b0, ST_OK,       END_CR},
    '{CH_STAR,    8'h05, 32'd100,        1'b0, ST_OK,       END_CR},
    '{CH_F,       8'h05, 32'd110,        1'b0, ST_OK,       END_CR},
    '{CH_CR,      8'h05, 32'd120,        1'b1, ST_SHORT,    END_CR},
    '{CH_STAR,    8'h05, 32'd130,        1'b0, ST_OK,       END_CR},
    '{8'h51,      8'h05, 32'd140,        1'b0, ST_OK,       END_CR},
    // channel change ends the frame and the breaking start mark opens a new one
    '{CH_STAR,    8'h06, 32'd150,        1'b1, ST_SHORT,    END_CHAN},
    '{8'hFF,      8'h06, 32'd160,        1'b0, ST_OK,       END_CR},
    '{8'h80,      8'h06, 32'd29985,      1'b0, ST_OK,       END_CR},
    '{8'hFF,      8'h06, 32'd59811,      1'b1, ST_SHORT,    END_GAP},
    '{8'h78,      8'h03, 32'h8000_0000,  1'b0, ST_OK,       END_CR},
    // timer wraps inside the frame
    '{CH_STAR,    8'hFF, 32'hFFFF_FFF0,  1'b0, ST_OK,       END_CR},
    '{CH_T,       8'hFF, 32'h0000_0010,  1'b0, ST_OK,       END_CR},
    '{CH_BANG,    8'hFF, 32'h0000_0020,  1'b0, ST_OK,       END_CR},
    '{CH_H,       8'hFF, 32'h0000_0030,  1'b0, ST_OK,       END_CR},
    '{8'h00,      8'hFF, 32'h0000_0040,  1'b0, ST_OK,       END_CR},
    '{8'hFF,      8'hFF, 32'h0000_0050,  1'b0, ST_OK,       END_CR},
    '{8'h00,      8'hFF, 32'h0000_0060,  1'b0, ST_OK,       END_CR},
    '{CH_CR,      8'hFF, 32'h0000_0070,  1'b1, ST_LRC_BAD,  END_CR}
  };

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_W-1:0]       in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_W-1:0]      out_tdata;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [19:0]           cfg_data   = '0;

  // tracker state, mirrors the block's frame collector
  logic                  busy       = 1'b0;
  logic [7:0]            chan_cur   = '0;
  logic [31:0]           stamp_last = '0;
  int unsigned           flen       = 0;
  logic [7:0]            sum_acc    = '0;
  logic [7:0]            last_byte  = '0;
  logic [7:0]            hdr_seen [5];
  logic                  ovf        = 1'b0;
  logic [19:0]           gap_lim    = GAP_LIMIT_RST;

  result_t               frames_due [$];
  logic                  row_typed  = 1'b0;
  result_t               row_want   = '0;

  int unsigned           send_idle  = 0;
  int unsigned           recv_stall = 0;
  int unsigned           bytes_sent = 0;
  int unsigned           frames_seen = 0;
  int unsigned           status_seen [7];
  int unsigned           errors     = 0;
  int unsigned           quiet      = 0;

  // random stream state
  logic [7:0]            chan       = '0;
  logic [31:0]           now        = '0;
  tail_t                 tail       = TAIL_CR;

  pump_link_frame_checker_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic result_t judge_frame(input cause_t cause);
    result_t     r;
    logic [7:0]  s;
    logic [7:0]  lrc;
    logic [7:0]  pp;
    logic [7:0]  v;
    r = '0;
    r.end_cause = cause;
    busy = 1'b0;
    if (ovf) begin
      r.frame_status = ST_TOO_LONG;
    end else if (flen < 7) begin
      r.frame_status = ST_SHORT;
    end else begin
      s = sum_acc - last_byte;
      lrc = ((~s) & LRC_MASK) + LRC_BASE;
      if (lrc != last_byte) begin
        r.frame_status = ST_LRC_BAD;
      end else if (hdr_seen[0] != CH_T && hdr_seen[0] != CH_F) begin
        r.frame_status = ST_BAD_DIR;
      end else begin
        // direction survives a bad pump, direction and pump survive a bad prepay
        r.is_master = (hdr_seen[0] == CH_T);
        if (hdr_seen[1] == CH_BANG) begin
          r.pump_number = 5'd0;
        end else if (hdr_seen[1] >= CH_ONE && hdr_seen[1] <= CH_AT) begin
          r.pump_number = 5'(hdr_seen[1] - DIGIT_BASE);
        end else begin
          r.frame_status = ST_BAD_PUMP;
        end
        if (r.frame_status == ST_OK) begin
          pp = r.is_master ? hdr_seen[2] : hdr_seen[4];
          if (pp == CH_H) begin
            r.prepay = 1'b1;
          end else if (pp != CH_A) begin
            r.frame_status = ST_BAD_PREPAY;
          end
        end
        if (r.frame_status == ST_OK) begin
          if (r.is_master) begin
            r.lockout_code   = hdr_seen[3];
            r.command_code   = hdr_seen[4];
            r.payload_length = 9'(flen - 7);
          end else begin
            r.lockout_code   = hdr_seen[4];
            r.command_code   = hdr_seen[3];
            r.payload_length = (flen >= 8) ? 9'(flen - 8) : 9'd0;
            if (hdr_seen[2] >= NOZ_BASE && hdr_seen[2] < NOZ_END) begin
              v = hdr_seen[2] - NOZ_BASE;
              r.nozzle_valid = 1'b1;
              r.nozzle_flags = {v[5], v[2:0]};
              r.hose_number  = 2'(2'd3 - v[4:3]);
            end
          end
        end
      end
    end
    return r;
  endfunction

  function automatic void hunt_from(input logic [7:0] b, input logic [7:0] ch,
                                    input logic [31:0] t);
    chan_cur   = ch;
    stamp_last = t;
    if (b == CH_STAR) begin
      busy      = 1'b1;
      flen      = 1;
      sum_acc   = '0;
      ovf       = 1'b0;
      last_byte = b;
    end
  endfunction

  // advance the tracker by one byte; returns 1 when a frame ended
  function automatic bit track_byte(input logic [7:0] b, input logic [7:0] ch,
                                    input logic [31:0] t, output result_t r);
    logic [31:0] gap;
    r = '0;
    gap = t - stamp_last;
    if (!busy) begin
      hunt_from(b, ch, t);
      return 1'b0;
    end
    if (ch != chan_cur) begin
      r = judge_frame(END_CHAN);
      hunt_from(b, ch, t);
      return 1'b1;
    end
    if (gap > 32'(gap_lim)) begin
      r = judge_frame(END_GAP);
      hunt_from(b, ch, t);
      return 1'b1;
    end
    stamp_last = t;
    if (b == CH_CR) begin
      r = judge_frame(END_CR);
      return 1'b1;
    end
    if (flen >= MAX_FRAME_DEF) begin
      ovf = 1'b1;
    end else begin
      if (flen >= 1 && flen <= 5) hdr_seen[flen-1] = b;
      if (flen >= 2) sum_acc = sum_acc + b;
      last_byte = b;
      flen++;
    end
    return 1'b0;
  endfunction

  task automatic flag_field(input string name, input logic [31:0] want, input logic [31:0] got);
    errors++;
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
  endtask

  task automatic compare_frame(input result_t want, input result_t got, input logic [3:0] pad);
    if (got.frame_status !== want.frame_status)
      flag_field("frame_status", want.frame_status, got.frame_status);
    if (got.end_cause !== want.end_cause)
      flag_field("end_cause", want.end_cause, got.end_cause);
    if (got.is_master !== want.is_master)
      flag_field("is_master", want.is_master, got.is_master);
    if (got.pump_number !== want.pump_number)
      flag_field("pump_number", want.pump_number, got.pump_number);
    if (got.prepay !== want.prepay)
      flag_field("prepay", want.prepay, got.prepay);
    if (got.lockout_code !== want.lockout_code)
      flag_field("lockout_code", want.lockout_code, got.lockout_code);
    if (got.command_code !== want.command_code)
      flag_field("command_code", want.command_code, got.command_code);
    if (got.nozzle_valid !== want.nozzle_valid)
      flag_field("nozzle_valid", want.nozzle_valid, got.nozzle_valid);
    if (got.nozzle_flags !== want.nozzle_flags)
      flag_field("nozzle_flags", want.nozzle_flags, got.nozzle_flags);
    if (got.hose_number !== want.hose_number)
      flag_field("hose_number", want.hose_number, got.hose_number);
    if (got.payload_length !== want.payload_length)
      flag_field("payload_length", want.payload_length, got.payload_length);
    if (pad !== 4'h0)
      flag_field("padding", 0, pad);
  endtask

  // results first, then the byte taken at the same edge (its result comes later)
  always @(posedge clk) begin : watch_blk
    result_t got;
    result_t calc;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = result_t'(out_tdata[43:0]);
        frames_seen++;
        if (int'(got.frame_status) < 7) status_seen[int'(got.frame_status)]++;
        if (frames_due.size() == 0) begin
          errors++;
          $display("%0t: result with nothing expected, expected none, got %h", $time, out_tdata);
        end else begin
          compare_frame(frames_due.pop_front(), got, out_tdata[47:44]);
        end
      end
      if (in_tvalid && in_tready) begin
        if (track_byte(in_tdata[7:0], in_tdata[15:8], in_tdata[47:16], calc))
          frames_due.push_back(row_typed ? row_want : calc);
      end
    end
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_stall);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet >= WATCH_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d results outstanding",
               $time, quiet, frames_due.size());
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic send_item(input logic [7:0] b, input logic [7:0] ch, input logic [31:0] t,
                           input logic typed, input result_t want);
    while ($urandom_range(0, 99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {t, ch, b};
    row_typed <= typed;
    row_want  <= want;
    do @(posedge clk); while (!in_tready);
    bytes_sent++;
    @(negedge clk);
  endtask

  // hold the sender until every frame result is back, then let the pipe drain
  task automatic settle();
    in_tvalid <= 1'b0;
    while (frames_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic load_gap_limit(input logic [19:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    gap_lim = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] next_stamp();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 32'(gap_lim);
    if (r < 3) return $urandom_range(0, gap_lim);
    return $urandom_range(0, (gap_lim < 50) ? gap_lim : 50);
  endfunction

  // one frame with random content; long_pay != 0 forces a long frame with a good LRC and a CR end
  task automatic send_random_frame(input int unsigned long_pay);
    logic [7:0]  fb [$];
    logic [7:0]  s;
    logic [7:0]  lrc;
    logic [7:0]  dir;
    logic [7:0]  pump;
    logic [7:0]  pp;
    logic [7:0]  nz;
    logic [7:0]  d;
    int unsigned pay;
    int unsigned keep;
    int unsigned r;
    int          i;
    // break the previous frame as planned, or wander after a CR
    case (tail)
      TAIL_CHAN: chan = chan ^ 8'($urandom_range(1, 255));
      TAIL_GAP:  now = now + gap_lim + 1 + $urandom_range(0, 3000);
      default: begin
        now = now + $urandom();
        if ($urandom_range(0, 4) == 0) chan = 8'($urandom_range(0, 255));
      end
    endcase
    if ($urandom_range(0, 6) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        send_item(8'($urandom_range(0, 255)), chan, now, 1'b0, '0);
        now = now + next_stamp();
      end
    end
    r = $urandom_range(0, 19);
    dir = (r < 9) ? CH_T : (r < 18) ? CH_F : 8'($urandom_range(0, 255));
    if ($urandom_range(0, 4) == 0) begin
      pump = 8'($urandom_range(0, 255));
    end else begin
      pump = 8'($urandom_range(8'h30, 8'h40));
      if (pump == DIGIT_BASE) pump = CH_BANG;
    end
    pp = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) :
         ($urandom_range(0, 1) ? CH_H : CH_A);
    nz = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) :
         8'($urandom_range(8'h3B, 8'h7F));
    fb.push_back(CH_STAR);
    fb.push_back(dir);
    fb.push_back(pump);
    fb.push_back((dir == CH_T) ? pp : nz);
    fb.push_back(8'($urandom_range(0, 255)));
    fb.push_back((dir == CH_T) ? 8'($urandom_range(0, 255)) : pp);
    pay = (long_pay != 0) ? long_pay : $urandom_range(0, 6);
    repeat (pay) begin
      d = 8'($urandom_range(0, 255));
      // keep long frames from ending early on a stray CR
      if (long_pay != 0 && d == CH_CR) d = 8'h0E;
      fb.push_back(d);
    end
    s = '0;
    for (i = 2; i < fb.size(); i++) s = s + fb[i];
    lrc = ((~s) & LRC_MASK) + LRC_BASE;
    if (long_pay == 0 && $urandom_range(0, 9) == 0) lrc = lrc ^ 8'($urandom_range(1, 255));
    fb.push_back(lrc);
    if (long_pay == 0 && $urandom_range(0, 9) == 0) begin
      keep = $urandom_range(1, 6);
      while (fb.size() > keep) void'(fb.pop_back());
    end
    for (i = 0; i < fb.size(); i++) begin
      if (i != 0) now = now + next_stamp();
      send_item(fb[i], chan, now, 1'b0, '0);
    end
    r = $urandom_range(0, 99);
    if (r < 70 || long_pay != 0) begin
      now = now + next_stamp();
      send_item(CH_CR, chan, now, 1'b0, '0);
      tail = TAIL_CR;
    end else begin
      tail = (r < 85) ? TAIL_GAP : TAIL_CHAN;
    end
  endtask

  initial begin : run_blk
    logic [19:0] gap_plan [4];
    int unsigned send_plan [4];
    int unsigned recv_plan [4];
    int unsigned budget [4];
    result_t     want;
    int unsigned start;
    int unsigned frames;
    int          k;
    int          phase;
    gap_plan  = '{20'd1000, 20'd0, 20'hFFFFF, 20'($urandom_range(1, 60000))};
    send_plan = '{0, 56, 0, 30};
    recv_plan = '{0, 0, 56, 30};
    budget    = '{120, 120, 540, 120};
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    for (k = 0; k < $size(DIRECTED_STEPS); k++) begin
      want = '0;
      want.frame_status = DIRECTED_STEPS[k].st;
      want.end_cause    = DIRECTED_STEPS[k].cs;
      send_item(DIRECTED_STEPS[k].b, DIRECTED_STEPS[k].ch, DIRECTED_STEPS[k].t,
                DIRECTED_STEPS[k].typed_exp, want);
    end

    for (phase = 0; phase < 4; phase++) begin
      settle();
      load_gap_limit(gap_plan[phase]);
      send_idle  = send_plan[phase];
      recv_stall = recv_plan[phase];
      now   = $urandom();
      chan  = 8'($urandom_range(0, 255));
      tail  = TAIL_CR;
      start = bytes_sent;
      frames = 0;
      while (bytes_sent - start < budget[phase]) begin
        // widest gap limit phase also carries a frame that just fits and one that overflows
        if (phase == 2 && frames == 0) send_random_frame(MAX_FRAME_DEF - 7);
        else if (phase == 2 && frames == 1) send_random_frame(MAX_FRAME_DEF - 5);
        else send_random_frame(0);
        frames++;
      end
    end
    settle();

    $display("Run covered %0d input bytes and %0d checked frames across four gap limits",
             bytes_sent, frames_seen);
    $display("Outcomes: ok %0d, short %0d, lrc %0d, dir %0d, pump %0d, prepay %0d, long %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             status_seen[4], status_seen[5], status_seen[6]);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* pump_link_frame_checker_core.f */
+incdir+sv
sv/plk_pkg.sv
sv/plk_tracker.sv
sv/plk_decode.sv
sv/pump_link_frame_checker_core.sv
sv/plk_checker.sv
test/tb_pump_link_frame_checker_core.sv
